// ===== rtl/arp_cache_responder_top_defines.svh =====
// Assertion macros shared by the ARP cache responder RTL.
`ifndef ARP_CACHE_RESPONDER_TOP_DEFINES_SVH
`define ARP_CACHE_RESPONDER_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define ARPCR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ARPCR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/arpcr_pkg.sv =====
// Types and constants of the ARP cache responder.
package arpcr_pkg;

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int HALF_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] FUNC_PKT     = 2'd0;
    localparam logic [1:0] FUNC_RESOLVE = 2'd1;
    localparam logic [1:0] FUNC_REMOVE  = 2'd2;

    localparam logic [HALF_W-1:0] HW_ETHERNET = 16'h0001;
    localparam logic [HALF_W-1:0] PROTO_IPV4  = 16'h0800;
    localparam logic [HALF_W-1:0] OP_REQUEST  = 16'h0001;
    localparam logic [HALF_W-1:0] OP_REPLY    = 16'h0002;

    localparam logic [1:0] OPER_NONE    = 2'd0;
    localparam logic [1:0] OPER_REQUEST = 2'd1;
    localparam logic [1:0] OPER_REPLY   = 2'd2;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd1;

    typedef enum logic [2:0] {
        ACT_LEARNED     = 3'd0,
        ACT_BAD_HW      = 3'd1,
        ACT_BAD_PROTO   = 3'd2,
        ACT_BAD_OP      = 3'd3,
        ACT_SEND_REPLY  = 3'd4,
        ACT_SEND_REQ    = 3'd5,
        ACT_RESOLVE_HIT = 3'd6,
        ACT_REMOVED     = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        K_SEARCH = 2'd0,
        K_UPDATE = 2'd1,
        K_FILL   = 2'd2,
        K_REMOVE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic              done;
        logic [MAC_W-1:0]  hit_mac;
    } t_tok;

    typedef struct packed {
        t_action           action;
        logic [MAC_W-1:0]  dest_mac;
        logic [1:0]        oper;
        logic [MAC_W-1:0]  s_mac;
        logic [IP_W-1:0]   s_ip;
        logic [MAC_W-1:0]  t_mac;
        logic [IP_W-1:0]   t_ip;
    } t_res;

endpackage

// ===== rtl/arpcr_cell.sv =====
// One cache entry of the lookup chain, acting on the command item passing by.
`include "arp_cache_responder_top_defines.svh"

module arpcr_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  arpcr_pkg::t_tok   i_tok,
    output logic              o_tok_valid,
    output arpcr_pkg::t_tok   o_tok
);

    logic                          r_valid;
    logic [arpcr_pkg::IP_W-1:0]    r_ip;
    logic [arpcr_pkg::MAC_W-1:0]   r_mac;
    logic                          r_tok_valid;
    arpcr_pkg::t_tok               r_tok;
    logic                          match;
    logic                          take;
    arpcr_pkg::t_tok               n_tok;

    assign match = r_valid && (r_ip == i_tok.ip);

    always_comb begin
        unique case (i_tok.kind)
            arpcr_pkg::K_FILL: take = i_tok_valid && !i_tok.done && !r_valid;
            default:           take = i_tok_valid && !i_tok.done && match;
        endcase
        n_tok = i_tok;
        if (take) begin
            n_tok.done = 1'b1;
            if (i_tok.kind == arpcr_pkg::K_SEARCH) begin
                n_tok.hit_mac = r_mac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
            if (take) begin
                unique case (i_tok.kind)
                    arpcr_pkg::K_SEARCH: r_valid <= r_valid;
                    arpcr_pkg::K_UPDATE: r_valid <= r_valid;
                    arpcr_pkg::K_FILL:   r_valid <= 1'b1;
                    arpcr_pkg::K_REMOVE: r_valid <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (take && (i_tok.kind == arpcr_pkg::K_FILL)) begin
            r_ip <= i_tok.ip;
        end
        if (take && ((i_tok.kind == arpcr_pkg::K_FILL) ||
                     (i_tok.kind == arpcr_pkg::K_UPDATE))) begin
            r_mac <= i_tok.mac;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

    `ARPCR_ASSERT(a_cell_valid_follows, o_tok_valid |-> $past(i_tok_valid), "Item left a cell without entering it.")
    `ARPCR_ASSERT_NEXT(a_cell_done_sticks, i_tok_valid && i_tok.done, o_tok.done, "A finished command was reopened.")

endmodule

// ===== rtl/arpcr_seq.sv =====
// Sequencer: takes items, runs search and write passes down the chain, builds results.
`include "arp_cache_responder_top_defines.svh"

module arpcr_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_func,
    input  logic [arpcr_pkg::HALF_W-1:0]        i_hw_type,
    input  logic [arpcr_pkg::HALF_W-1:0]        i_proto_type,
    input  logic [arpcr_pkg::HALF_W-1:0]        i_operation,
    input  logic [arpcr_pkg::MAC_W-1:0]         i_sender_mac,
    input  logic [arpcr_pkg::IP_W-1:0]          i_sender_ip,
    input  logic [arpcr_pkg::MAC_W-1:0]         i_target_mac,
    input  logic [arpcr_pkg::IP_W-1:0]          i_target_ip,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arpcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [arpcr_pkg::MAC_W-1:0]         i_cfg_data,
    output logic                                o_head_valid,
    output arpcr_pkg::t_tok                     o_head,
    input  logic                                i_tail_valid,
    input  arpcr_pkg::t_tok                     i_tail,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output arpcr_pkg::t_res                     o_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    typedef enum logic [5:0] {
        STEP_LS_SRCH  = 6'b000001,
        STEP_LS_WR    = 6'b000010,
        STEP_LT_SRCH  = 6'b000100,
        STEP_LT_WR    = 6'b001000,
        STEP_TGT_SRCH = 6'b010000,
        STEP_REMOVE   = 6'b100000
    } t_step;

    t_state                        r_state, n_state;
    t_step                         r_step, n_step;
    logic                          r_launch, n_launch;
    logic                          r_wr_upd, n_wr_upd;
    logic                          r_out_valid, n_out_valid;
    arpcr_pkg::t_res               r_res, n_res;
    arpcr_pkg::t_res               r_out, n_out;
    logic [1:0]                    r_func;
    logic                          r_is_req;
    logic [arpcr_pkg::MAC_W-1:0]   r_smac, r_tmac;
    logic [arpcr_pkg::IP_W-1:0]    r_sip, r_tip;
    logic [arpcr_pkg::MAC_W-1:0]   r_own_mac;
    logic [arpcr_pkg::IP_W-1:0]    r_own_ip;
    logic                          in_acc;
    logic                          out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_head.done    = 1'b0;
        o_head.hit_mac = '0;
        unique case (r_step)
            STEP_LS_SRCH: begin
                o_head.kind = arpcr_pkg::K_SEARCH;
                o_head.ip   = r_sip;
                o_head.mac  = r_smac;
            end
            STEP_LS_WR: begin
                o_head.kind = r_wr_upd ? arpcr_pkg::K_UPDATE : arpcr_pkg::K_FILL;
                o_head.ip   = r_sip;
                o_head.mac  = r_smac;
            end
            STEP_LT_SRCH: begin
                o_head.kind = arpcr_pkg::K_SEARCH;
                o_head.ip   = r_tip;
                o_head.mac  = r_tmac;
            end
            STEP_LT_WR: begin
                o_head.kind = r_wr_upd ? arpcr_pkg::K_UPDATE : arpcr_pkg::K_FILL;
                o_head.ip   = r_tip;
                o_head.mac  = r_tmac;
            end
            STEP_TGT_SRCH: begin
                o_head.kind = arpcr_pkg::K_SEARCH;
                o_head.ip   = r_tip;
                o_head.mac  = r_tmac;
            end
            default: begin
                o_head.kind = arpcr_pkg::K_REMOVE;
                o_head.ip   = r_tip;
                o_head.mac  = r_tmac;
            end
        endcase
    end
    assign o_head_valid = r_launch;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_launch    = 1'b0;
        n_wr_upd    = r_wr_upd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    priority if (i_func == arpcr_pkg::FUNC_PKT) begin
                        priority if (i_hw_type != arpcr_pkg::HW_ETHERNET) begin
                            n_res.action = arpcr_pkg::ACT_BAD_HW;
                            n_state      = ST_EMIT;
                        end else if (i_proto_type != arpcr_pkg::PROTO_IPV4) begin
                            n_res.action = arpcr_pkg::ACT_BAD_PROTO;
                            n_state      = ST_EMIT;
                        end else if ((i_operation == arpcr_pkg::OP_REQUEST) ||
                                     (i_operation == arpcr_pkg::OP_REPLY)) begin
                            n_step   = STEP_LS_SRCH;
                            n_launch = 1'b1;
                            n_state  = ST_RUN;
                        end else begin
                            n_res.action = arpcr_pkg::ACT_BAD_OP;
                            n_state      = ST_EMIT;
                        end
                    end else if (i_func == arpcr_pkg::FUNC_RESOLVE) begin
                        n_step   = STEP_TGT_SRCH;
                        n_launch = 1'b1;
                        n_state  = ST_RUN;
                    end else if (i_func == arpcr_pkg::FUNC_REMOVE) begin
                        n_step   = STEP_REMOVE;
                        n_launch = 1'b1;
                        n_state  = ST_RUN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RUN: begin
                if (i_tail_valid) begin
                    n_res = '0;
                    unique case (r_step)
                        STEP_LS_SRCH: begin
                            n_step   = STEP_LS_WR;
                            n_wr_upd = i_tail.done;
                            n_launch = 1'b1;
                        end
                        STEP_LS_WR: begin
                            priority if (r_is_req) begin
                                n_step   = STEP_TGT_SRCH;
                                n_launch = 1'b1;
                            end else if (r_tmac != arpcr_pkg::BCAST_MAC) begin
                                n_step   = STEP_LT_SRCH;
                                n_launch = 1'b1;
                            end else begin
                                n_res.action = arpcr_pkg::ACT_LEARNED;
                                n_state      = ST_EMIT;
                            end
                        end
                        STEP_LT_SRCH: begin
                            n_step   = STEP_LT_WR;
                            n_wr_upd = i_tail.done;
                            n_launch = 1'b1;
                        end
                        STEP_LT_WR: begin
                            n_res.action = arpcr_pkg::ACT_LEARNED;
                            n_state      = ST_EMIT;
                        end
                        STEP_TGT_SRCH: begin
                            n_state = ST_EMIT;
                            priority if (r_func == arpcr_pkg::FUNC_RESOLVE) begin
                                if (i_tail.done) begin
                                    n_res.action   = arpcr_pkg::ACT_RESOLVE_HIT;
                                    n_res.dest_mac = i_tail.hit_mac;
                                end else begin
                                    n_res.action   = arpcr_pkg::ACT_SEND_REQ;
                                    n_res.dest_mac = arpcr_pkg::BCAST_MAC;
                                    n_res.oper     = arpcr_pkg::OPER_REQUEST;
                                    n_res.s_mac    = r_own_mac;
                                    n_res.s_ip     = r_own_ip;
                                    n_res.t_ip     = r_tip;
                                end
                            end else if (i_tail.done) begin
                                n_res.action   = arpcr_pkg::ACT_SEND_REPLY;
                                n_res.dest_mac = r_smac;
                                n_res.oper     = arpcr_pkg::OPER_REPLY;
                                n_res.s_mac    = r_own_mac;
                                n_res.s_ip     = r_tip;
                                n_res.t_mac    = r_smac;
                                n_res.t_ip     = r_sip;
                            end else begin
                                n_res.action = arpcr_pkg::ACT_LEARNED;
                            end
                        end
                        default: begin
                            n_res.action = arpcr_pkg::ACT_REMOVED;
                            n_state      = ST_EMIT;
                        end
                    endcase
                end
            end
            default: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_LS_SRCH;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_own_mac   <= '0;
            r_own_ip    <= '0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    arpcr_pkg::CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                    default:                r_own_ip  <= i_cfg_data[arpcr_pkg::IP_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_upd <= n_wr_upd;
        r_res    <= n_res;
        r_out    <= n_out;
        if (in_acc) begin
            r_func   <= i_func;
            r_is_req <= (i_operation == arpcr_pkg::OP_REQUEST);
            r_smac   <= i_sender_mac;
            r_sip    <= i_sender_ip;
            r_tmac   <= i_target_mac;
            r_tip    <= i_target_ip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    `ARPCR_ASSERT(a_launch_in_run, r_launch |-> (r_state == ST_RUN), "Command launched outside a run.")
    `ARPCR_ASSERT(a_one_in_flight, i_tail_valid |-> !r_launch, "Two commands in the chain at once.")
    `ARPCR_ASSERT_NEXT(a_tail_advances, i_tail_valid, (r_state != ST_RUN) || r_launch, "Run stalled after a pass ended.")

endmodule

// ===== rtl/arp_cache_responder_top.sv =====
// Top level of the ARP cache responder: sequencer and a chain of cache entry cells.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_stall    i_func .. i_target_ip
//   out      output     o_out_valid / i_out_stall  o_action .. o_out_target_ip
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each cache lookup or write is one pass of a command down the chain. An item
// needs one pass (resolve, remove), three (request) or two or four (reply);
// a packet rejected for its hardware type, protocol type or operation needs none.
// One item is worked on at a time; the next is taken while a result waits.
// Reset is synchronous and clears all cache entries at once.
module arp_cache_responder_top #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_func,
    input  logic [15:0]                         i_hw_type,
    input  logic [15:0]                         i_proto_type,
    input  logic [15:0]                         i_operation,
    input  logic [47:0]                         i_sender_mac,
    input  logic [31:0]                         i_sender_ip,
    input  logic [47:0]                         i_target_mac,
    input  logic [31:0]                         i_target_ip,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_action,
    output logic [47:0]                         o_dest_mac,
    output logic [1:0]                          o_out_operation,
    output logic [47:0]                         o_out_sender_mac,
    output logic [31:0]                         o_out_sender_ip,
    output logic [47:0]                         o_out_target_mac,
    output logic [31:0]                         o_out_target_ip,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arpcr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [47:0]                         i_cfg_data
);

    logic              tok_valid [CACHE_ENTRIES+1];
    arpcr_pkg::t_tok   tok       [CACHE_ENTRIES+1];
    arpcr_pkg::t_res   res;

    arpcr_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_hw_type    (i_hw_type),
        .i_proto_type (i_proto_type),
        .i_operation  (i_operation),
        .i_sender_mac (i_sender_mac),
        .i_sender_ip  (i_sender_ip),
        .i_target_mac (i_target_mac),
        .i_target_ip  (i_target_ip),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_head_valid (tok_valid[0]),
        .o_head       (tok[0]),
        .i_tail_valid (tok_valid[CACHE_ENTRIES]),
        .i_tail       (tok[CACHE_ENTRIES]),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_res        (res)
    );

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        arpcr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok_valid (tok_valid[g]),
            .i_tok       (tok[g]),
            .o_tok_valid (tok_valid[g+1]),
            .o_tok       (tok[g+1])
        );
    end

    assign o_action         = res.action;
    assign o_dest_mac       = res.dest_mac;
    assign o_out_operation  = res.oper;
    assign o_out_sender_mac = res.s_mac;
    assign o_out_sender_ip  = res.s_ip;
    assign o_out_target_mac = res.t_mac;
    assign o_out_target_ip  = res.t_ip;

endmodule
